[rtl/core/segment_segment_intersection_unit_defines.svh]
// assertion macros shared by the checker
`ifndef SEGMENT_SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define SEGMENT_SEGMENT_INTERSECTION_UNIT_DEFINES_SVH

// implication checked on every clock outside reset
`define SSI_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("ssi check failed");

// next-cycle implication checked outside reset
`define SSI_ASSERT_NXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("ssi check failed");

`endif

[rtl/core/ssi_pkg.sv]
`default_nettype none
package ssi_pkg;
  // fixed output width of the intersection point
  localparam int unsigned OUT_BITS = 32;
  // valid and hit bits of the output register
  typedef struct packed {
    logic valid;
    logic hit;
  } ssi_ctl_t;
endpackage
`default_nettype wire

[rtl/core/ssi_divider.sv]
`default_nettype none
// pipelined signed divider, one quotient bit per stage, truncates toward zero
module ssi_divider #(
  parameter int unsigned NUM_BITS = 72,
  parameter int unsigned DEN_BITS = 40,
  parameter int unsigned TAG_BITS = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic signed [NUM_BITS-1:0] num,
  input  wire logic signed [DEN_BITS-1:0] den,
  input  wire logic        [TAG_BITS-1:0] in_tag,
  output logic                            out_valid,
  output logic signed      [NUM_BITS-1:0] quo,
  output logic             [TAG_BITS-1:0] out_tag
);
  localparam int unsigned R_BITS = DEN_BITS + 1;

  logic                valid [NUM_BITS+1];
  logic [NUM_BITS-1:0] q     [NUM_BITS+1];
  logic [R_BITS-1:0]   rem   [NUM_BITS+1];
  logic [DEN_BITS-1:0] dmag  [NUM_BITS+1];
  logic                neg   [NUM_BITS+1];
  logic [TAG_BITS-1:0] tag   [NUM_BITS+1];

  // magnitude taken on entry
  always_comb begin
    valid[0] = in_valid;
    q[0]     = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
    dmag[0]  = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);
    neg[0]   = num[NUM_BITS-1] ^ den[DEN_BITS-1];
    rem[0]   = '0;
    tag[0]   = in_tag;
  end

  // restoring steps, one register per quotient bit
  for (genvar i = 0; i < NUM_BITS; i++) begin : g_step
    logic [R_BITS-1:0]   sh;
    logic [R_BITS:0]     diff;
    always_comb begin
      sh   = {rem[i][R_BITS-2:0], q[i][NUM_BITS-1]};
      diff = {1'b0, sh} - {2'b00, dmag[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
      rem[i+1]  <= diff[R_BITS] ? sh : diff[R_BITS-1:0];
      q[i+1]    <= {q[i][NUM_BITS-2:0], ~diff[R_BITS]};
      dmag[i+1] <= dmag[i];
      neg[i+1]  <= neg[i];
      tag[i+1]  <= tag[i];
    end
  end

  // sign restored on exit
  assign out_valid = valid[NUM_BITS];
  assign quo       = neg[NUM_BITS] ? NUM_BITS'(-q[NUM_BITS]) : q[NUM_BITS];
  assign out_tag   = tag[NUM_BITS];
endmodule
`default_nettype wire

[rtl/core/segment_segment_intersection_unit.sv]
`default_nettype none
// segment intersection unit
// a request is taken when start is high and busy is low; busy is always low,
// so a new pair of segments may be given on every clock.
// each request gives exactly one result, shown for one cycle with done high:
// hit, and the point cross_x, cross_y in signed fixed point with FRAC_BITS
// fraction bits (zero when there is no hit or the segments are parallel).
// from the accepting edge to the edge that takes the result a request passes
// five arithmetic stages, one divider stage per bit of the scaled numerator
// base*d + na*delta and the output register; throughput one request per cycle.
// results appear in request order. the receiver cannot stall: done is a
// strobe and the result must be taken in that cycle.
// reset (rst, synchronous) clears all valid bits; payload is not cleared.
module segment_segment_intersection_unit #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] a_start_x,
  input  wire logic signed [COORD_BITS-1:0] a_start_y,
  input  wire logic signed [COORD_BITS-1:0] a_end_x,
  input  wire logic signed [COORD_BITS-1:0] a_end_y,
  input  wire logic signed [COORD_BITS-1:0] b_start_x,
  input  wire logic signed [COORD_BITS-1:0] b_start_y,
  input  wire logic signed [COORD_BITS-1:0] b_end_x,
  input  wire logic signed [COORD_BITS-1:0] b_end_y,
  output logic                              done,
  output logic                              hit,
  output logic signed [ssi_pkg::OUT_BITS-1:0] cross_x,
  output logic signed [ssi_pkg::OUT_BITS-1:0] cross_y
);
  localparam int unsigned DW = COORD_BITS + 1;       // differences
  localparam int unsigned PW = 2 * DW + 1;           // products and d
  localparam int unsigned TW = PW + COORD_BITS + 1;  // base*d + na*delta
  localparam int unsigned NW = TW + FRAC_BITS;       // scaled numerator

  assign busy = 1'b0;

  // stage 1: differences
  logic                 v1;
  logic signed [DW-1:0] dax, day, dbx, dby, wx, wy;
  logic signed [COORD_BITS-1:0] x1_1, y1_1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    dax  <= DW'(a_end_x) - DW'(a_start_x);
    day  <= DW'(a_end_y) - DW'(a_start_y);
    dbx  <= DW'(b_end_x) - DW'(b_start_x);
    dby  <= DW'(b_end_y) - DW'(b_start_y);
    wx   <= DW'(a_start_x) - DW'(b_start_x);
    wy   <= DW'(a_start_y) - DW'(b_start_y);
    x1_1 <= a_start_x;
    y1_1 <= a_start_y;
  end

  // stage 2: six products
  logic                     v2;
  logic signed [2*DW-1:0]   p0, p1, p2, p3, p4, p5;
  logic signed [DW-1:0]     dax2, day2;
  logic signed [COORD_BITS-1:0] x1_2, y1_2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    p0   <= dby * dax;
    p1   <= dbx * day;
    p2   <= dbx * wy;
    p3   <= dby * wx;
    p4   <= dax * wy;
    p5   <= day * wx;
    dax2 <= dax;
    day2 <= day;
    x1_2 <= x1_1;
    y1_2 <= y1_1;
  end

  // stage 3: d, na, nb
  logic                     v3;
  logic signed [PW-1:0]     d3, na3, nb3;
  logic signed [DW-1:0]     dax3, day3;
  logic signed [COORD_BITS-1:0] x1_3, y1_3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    d3   <= PW'(p0) - PW'(p1);
    na3  <= PW'(p2) - PW'(p3);
    nb3  <= PW'(p4) - PW'(p5);
    dax3 <= dax2;
    day3 <= day2;
    x1_3 <= x1_2;
    y1_3 <= y1_2;
  end

  // range test by sign and magnitude compare
  logic hit3;
  always_comb begin
    if (d3 > 0) begin
      hit3 = (na3 >= 0) && (na3 <= d3) && (nb3 >= 0) && (nb3 <= d3);
    end else if (d3 < 0) begin
      hit3 = (na3 <= 0) && (na3 >= d3) && (nb3 <= 0) && (nb3 >= d3);
    end else begin
      hit3 = 1'b0;
    end
  end

  // stage 4: base*d and na*delta for x and y (four multipliers)
  logic                     v4, hit4;
  logic signed [TW-1:0]     bx4, by4, nx4, ny4;
  logic signed [PW-1:0]     d4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    hit4 <= hit3;
    bx4  <= TW'(x1_3) * TW'(d3);
    by4  <= TW'(y1_3) * TW'(d3);
    nx4  <= TW'(na3) * TW'(dax3);
    ny4  <= TW'(na3) * TW'(day3);
    d4   <= d3;
  end

  // stage 5: scaled numerators; den forced non-zero when d is zero
  logic                     v5, hit5;
  logic signed [NW-1:0]     tx5, ty5;
  logic signed [PW-1:0]     d5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    hit5 <= hit4;
    tx5  <= NW'(bx4 + nx4) <<< FRAC_BITS;
    ty5  <= NW'(by4 + ny4) <<< FRAC_BITS;
    d5   <= (d4 == '0) ? PW'(1) : d4;
  end

  // truncating divide of scaled numerator by d, both axes
  logic                vqx, vqy, hqx, hqy;
  logic signed [NW-1:0] qx, qy;
  ssi_divider #(.NUM_BITS(NW), .DEN_BITS(PW), .TAG_BITS(1)) u_div_x (
    .clk(clk), .rst(rst), .in_valid(v5), .num(tx5), .den(d5), .in_tag(hit5),
    .out_valid(vqx), .quo(qx), .out_tag(hqx)
  );
  ssi_divider #(.NUM_BITS(NW), .DEN_BITS(PW), .TAG_BITS(1)) u_div_y (
    .clk(clk), .rst(rst), .in_valid(v5), .num(ty5), .den(d5), .in_tag(hit5),
    .out_valid(vqy), .quo(qy), .out_tag(hqy)
  );

  // output register
  ssi_pkg::ssi_ctl_t ctl;
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= vqx & vqy;
    end
    ctl.hit <= hqx & hqy;
    cross_x <= hqx ? ssi_pkg::OUT_BITS'(qx) : '0;
    cross_y <= hqy ? ssi_pkg::OUT_BITS'(qy) : '0;
  end

  assign done = ctl.valid;
  assign hit  = ctl.hit;
endmodule
`default_nettype wire

[rtl/core/ssi_checker.sv]
`default_nettype none
`include "segment_segment_intersection_unit_defines.svh"
// port-level checks on the intersection unit
module ssi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        hit,
  input wire logic [31:0] cross_x,
  input wire logic [31:0] cross_y
);
  // never refuses a request
  `SSI_ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy)
  // a miss shows a zero point
  `SSI_ASSERT_IMP(a_miss_zero, clk, rst, done && !hit, cross_x == 0 && cross_y == 0)
  // no output straight after reset
  `SSI_ASSERT_NXT(a_quiet_after_reset, clk, 1'b0, rst, !done)
endmodule

bind segment_segment_intersection_unit ssi_checker u_ssi_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .hit(hit),
  .cross_x(cross_x), .cross_y(cross_y)
);
`default_nettype wire
